FILE: rtl/itr_pkg.sv
// itr_pkg: widths, ascii codes, controller states and the command and status
// structs shared by the integer-to-radix-text block
// depends on nothing
`default_nettype none

package itr_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W     = $clog2(VALUE_BITS);
    localparam int BIT_W      = $clog2(VALUE_BITS);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = 8'h61;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'h2d;
    localparam logic [CHAR_W-1:0]  CHAR_NONE     = 8'h00;
    localparam logic [RADIX_W-1:0] DECIMAL_RADIX = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_TEN     = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MINUS,
        S_READ,
        S_EMIT,
        S_ERROR
    } t_itr_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic rd_issue;
        logic out_minus;
        logic out_digit;
        logic out_error;
    } t_itr_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic neg;
        logic div_done;
        logic quo_zero;
        logic cnt_zero;
        logic out_free;
    } t_itr_sts;

endpackage

`default_nettype wire

FILE: rtl/itr_if.sv
// itr_in_if and itr_out_if: valid/ready channels for the input numbers and
// the output characters; depends on itr_pkg
`default_nettype none

interface itr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [itr_pkg::VALUE_BITS-1:0] value;
    logic [itr_pkg::RADIX_W-1:0]         radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itr_out_if;
    logic                       valid;
    logic                       ready;
    logic [itr_pkg::CHAR_W-1:0] character;
    logic                       last;
    logic                       bad_radix;

    modport source (output valid, output character, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last, input bad_radix,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/itr_ram.sv
// itr_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module itr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/itr_datapath.sv
// itr_datapath: operand registers, bit-serial restoring divider, digit stack
// and output register; depends on itr_pkg and itr_ram
`default_nettype none

module itr_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire itr_pkg::t_itr_cmd                 i_cmd,
    input  wire logic signed [itr_pkg::VALUE_BITS-1:0] i_value,
    input  wire logic [itr_pkg::RADIX_W-1:0]       i_radix,
    input  wire logic                              i_out_ready,
    output itr_pkg::t_itr_sts                      o_sts,
    output logic                                   o_out_valid,
    output logic [itr_pkg::CHAR_W-1:0]             o_character,
    output logic                                   o_last,
    output logic                                   o_bad_radix
);

    localparam int VB = itr_pkg::VALUE_BITS;
    localparam int RW = itr_pkg::RADIX_W;
    localparam int CW = itr_pkg::CHAR_W;

    logic [VB-1:0]               r_quo, n_quo;
    logic [RW-1:0]               r_rem, n_rem;
    logic [RW-1:0]               r_radix;
    logic [itr_pkg::BIT_W-1:0]   r_bit;
    logic [itr_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_bad, r_neg;
    logic                        r_out_valid;
    logic [CW-1:0]               r_char;
    logic                        r_last, r_bad_out;

    logic [RW:0]                 trial;
    logic                        ge;
    logic [CW-1:0]               digit_ch;
    logic [CW-1:0]               rd_data;
    logic                        in_neg, in_bad, out_free, out_load;

    assign in_neg = (i_radix == itr_pkg::DECIMAL_RADIX) && i_value[VB-1];
    assign in_bad = (i_radix < itr_pkg::RADIX_MIN) || (i_radix > itr_pkg::RADIX_MAX);

    // one quotient bit per step
    always_comb begin
        trial = {r_rem, r_quo[VB-1]};
        ge    = trial >= {1'b0, r_radix};
        n_rem = ge ? RW'(trial - {1'b0, r_radix}) : RW'(trial);
        n_quo = {r_quo[VB-2:0], ge};
        if (n_rem < itr_pkg::DIGIT_TEN) begin
            digit_ch = itr_pkg::CHAR_ZERO + CW'(n_rem);
        end else begin
            digit_ch = itr_pkg::CHAR_LETTER_A + CW'(n_rem - itr_pkg::DIGIT_TEN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_quo   <= in_neg ? VB'(0 - i_value) : VB'(i_value);
            r_radix <= i_radix;
            r_rem   <= '0;
            r_bit   <= itr_pkg::BIT_W'(VB - 1);
            r_cnt   <= '0;
            r_bad   <= in_bad;
            r_neg   <= in_neg;
        end else if (i_cmd.step) begin
            r_quo <= n_quo;
            if (r_bit == '0) begin
                r_rem <= '0;
                r_bit <= itr_pkg::BIT_W'(VB - 1);
                r_cnt <= r_cnt + itr_pkg::CNT_W'(1);
            end else begin
                r_rem <= n_rem;
                r_bit <= r_bit - itr_pkg::BIT_W'(1);
            end
        end else if (i_cmd.rd_issue) begin
            r_cnt <= r_cnt - itr_pkg::CNT_W'(1);
        end
    end

    itr_ram #(
        .WIDTH (CW),
        .DEPTH (VB)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.step && (r_bit == '0)),
        .i_wr_addr (r_cnt[itr_pkg::ADDR_W-1:0]),
        .i_wr_data (digit_ch),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (itr_pkg::ADDR_W'(r_cnt - itr_pkg::CNT_W'(1))),
        .o_rd_data (rd_data)
    );

    // output register
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = i_cmd.out_minus || i_cmd.out_digit || i_cmd.out_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_minus) begin
            r_char    <= itr_pkg::CHAR_MINUS;
            r_last    <= 1'b0;
            r_bad_out <= 1'b0;
        end else if (i_cmd.out_digit) begin
            r_char    <= rd_data;
            r_last    <= (r_cnt == '0);
            r_bad_out <= 1'b0;
        end else if (i_cmd.out_error) begin
            r_char    <= itr_pkg::CHAR_NONE;
            r_last    <= 1'b1;
            r_bad_out <= 1'b1;
        end
    end

    assign o_sts.bad      = r_bad;
    assign o_sts.neg      = r_neg;
    assign o_sts.div_done = (r_bit == '0);
    assign o_sts.quo_zero = (n_quo == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad_out;

endmodule

`default_nettype wire

FILE: rtl/itr_ctrl.sv
// itr_ctrl: sequencer for load, division, sign, digit readout and error
// depends on itr_pkg
`default_nettype none

module itr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire itr_pkg::t_itr_sts i_sts,
    output logic                   o_in_ready,
    output itr_pkg::t_itr_cmd      o_cmd
);

    itr_pkg::t_itr_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            itr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = itr_pkg::S_CHECK;
                end
            end
            itr_pkg::S_CHECK: begin
                n_state = i_sts.bad ? itr_pkg::S_ERROR : itr_pkg::S_DIV;
            end
            itr_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_done && i_sts.quo_zero) begin
                    n_state = i_sts.neg ? itr_pkg::S_MINUS : itr_pkg::S_READ;
                end
            end
            itr_pkg::S_MINUS: begin
                if (i_sts.out_free) begin
                    o_cmd.out_minus = 1'b1;
                    n_state         = itr_pkg::S_READ;
                end
            end
            itr_pkg::S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = itr_pkg::S_EMIT;
            end
            itr_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_digit = 1'b1;
                    n_state = i_sts.cnt_zero ? itr_pkg::S_IDLE : itr_pkg::S_READ;
                end
            end
            itr_pkg::S_ERROR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_error = 1'b1;
                    n_state         = itr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = itr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/integer_to_radix_text.sv
// integer_to_radix_text: top level, joins the controller and the datapath
// to the input and output channels; depends on itr_pkg, itr_if, itr_ctrl,
// itr_datapath
`default_nettype none

// Converts a 32-bit two's-complement value to ascii text in a radix from 2 to
// 36, one character per output transfer, most significant digit first, with
// lower-case letters for digits above 9. In radix 10 a negative value comes
// out as '-' then its magnitude (the most negative value gives 2147483648);
// in every other radix the bit pattern is converted as unsigned. The final
// character of each number has last set. A radix outside 2 to 36 gives a
// single transfer with character 0, last and bad_radix set. One number is
// worked on at a time: the input is ready again once the last character has
// been loaded into the output register, so the next number can be taken while
// that character still waits. Each digit comes from a restoring divider that
// retires one quotient bit per cycle. Digits come out of the divider least
// significant first and go onto a 32-entry stack ram, which is then read back
// top down through its registered read port, one read per character.
module integer_to_radix_text (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itr_in_if.sink     i_in,
    itr_out_if.source  o_out
);

    itr_pkg::t_itr_cmd cmd;
    itr_pkg::t_itr_sts sts;
    logic              in_ready;

    // sequencer: accept, divide, emit sign, read back digits, or report a bad radix
    itr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // divider, digit stack and output register
    itr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_in.value),
        .i_radix     (i_in.radix),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_character (o_out.character),
        .o_last      (o_out.last),
        .o_bad_radix (o_out.bad_radix)
    );

    assign i_in.ready = in_ready;

    // only one number in flight: no second input transfer right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a number is still in progress");

    // an error result is a single zero character marked last
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_radix) |->
            (o_out.character == itr_pkg::CHAR_NONE) && o_out.last)
        else $error("bad radix result not a lone zero character");

    // a valid character is never the zero code
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.bad_radix) |-> (o_out.character != itr_pkg::CHAR_NONE))
        else $error("zero character on a good result");

    // while a number is being divided the output register gets nothing new
    a_no_out_during_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !(cmd.out_minus || cmd.out_digit || cmd.out_error))
        else $error("output load during division");

endmodule

`default_nettype wire

FILE: verif/integer_to_radix_text_tb.sv
`timescale 1ns / 100ps
// integer_to_radix_text_tb: self-checking bench for the integer-to-radix-text block,
// directed edge cases then random numbers and bases with random idling on both sides
// depends on itr_pkg, itr_if and the integer_to_radix_text rtl

module integer_to_radix_text_tb;

    localparam int RANDOM_NUMBERS = 480;
    localparam int STALL_LIMIT    = 20000;  // cycles with no transfer at all
    localparam int DRAIN_CYCLES   = 80;
    localparam int IDLE_PERCENT   = 27;
    localparam int CALM_FIRST     = 200;    // numbers taken while nobody idles
    localparam int CALM_LAST      = 280;
    localparam int REPORT_MAX     = 10;

    localparam int VB = itr_pkg::VALUE_BITS;
    localparam int RW = itr_pkg::RADIX_W;
    localparam int CW = itr_pkg::CHAR_W;

    typedef struct packed {
        logic [VB-1:0] value;
        logic [RW-1:0] radix;
    } t_number;

    typedef struct packed {
        logic [CW-1:0] code;
        logic          last;
        logic          bad;
    } t_text_char;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // drive registers, tied onto the channels below
    logic          in_valid  = 1'b0;
    logic [VB-1:0] in_value  = '0;
    logic [RW-1:0] in_radix  = '0;
    logic          out_ready = 1'b0;

    itr_in_if  in_ch ();
    itr_out_if out_ch ();

    assign in_ch.valid  = in_valid;
    assign in_ch.value  = in_value;
    assign in_ch.radix  = in_radix;
    assign out_ch.ready = out_ready;

    integer_to_radix_text u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_number    pending_numbers[$];
    t_text_char expected_chars[$];

    int  numbers_taken  = 0;
    int  chars_checked  = 0;
    int  bad_radix_seen = 0;
    int  minus_seen     = 0;
    int  mismatches     = 0;
    int  stall_cycles   = 0;
    logic calm;

    // a window in the middle of the run with no idling on either side
    assign calm = (numbers_taken >= CALM_FIRST) && (numbers_taken < CALM_LAST);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // expected text of one number: digits are built least significant first,
    // then queued most significant first with the last mark on the final one
    function automatic void predict_text(input logic [VB-1:0] value,
                                         input logic [RW-1:0] radix);
        logic [VB-1:0] mag;
        logic [VB-1:0] digit;
        logic [CW-1:0] ch;
        logic [CW-1:0] digits[$];
        logic          negative;
        if (radix < itr_pkg::RADIX_MIN || radix > itr_pkg::RADIX_MAX) begin
            expected_chars.push_back('{itr_pkg::CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        // only decimal gets a sign; other bases see the raw bit pattern
        negative = (radix == itr_pkg::DECIMAL_RADIX) && value[VB-1];
        mag = negative ? (~value + 1'b1) : value;
        do begin
            digit = mag % radix;
            if (digit < itr_pkg::DIGIT_TEN)
                digits.push_back(itr_pkg::CHAR_ZERO + digit[CW-1:0]);
            else
                digits.push_back(itr_pkg::CHAR_LETTER_A + digit[CW-1:0]
                                 - CW'(itr_pkg::DIGIT_TEN));
            mag = mag / radix;
        end while (mag != '0);
        if (negative)
            expected_chars.push_back('{itr_pkg::CHAR_MINUS, 1'b0, 1'b0});
        while (digits.size() > 0) begin
            ch = digits.pop_back();
            expected_chars.push_back('{ch, digits.size() == 0, 1'b0});
        end
    endfunction

    task automatic add_number(input logic [VB-1:0] value,
                              input logic [RW-1:0] radix);
        pending_numbers.push_back('{value, radix});
    endtask

    // mix of full-range, short, negative and power-of-two-ish values
    function automatic logic [VB-1:0] pick_value();
        logic [VB-1:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 40);
            4:       v = -$urandom_range(1, 40);
            5:       v = (32'd1 << $urandom_range(31)) - $urandom_range(0, 1);
            6:       v = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: v = $urandom >> $urandom_range(31);
        endcase
        return v;
    endfunction

    // decimal and the power-of-two bases often, any base now and then
    function automatic logic [RW-1:0] pick_radix();
        logic [RW-1:0] r;
        case ($urandom_range(19))
            0, 1, 2, 3: r = itr_pkg::DECIMAL_RADIX;
            4:          r = 6'd16;
            5:          r = 6'd2;
            6:          r = 6'd8;
            7:          r = RW'($urandom_range(63));
            8:          r = itr_pkg::RADIX_MAX - RW'($urandom_range(0, 1));
            default:    r = RW'($urandom_range(itr_pkg::RADIX_MIN, itr_pkg::RADIX_MAX));
        endcase
        return r;
    endfunction

    // input driver: holds an offered number until it is taken, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ch.ready) begin
            if (pending_numbers.size() > 0 &&
                (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                in_valid <= 1'b1;
                in_value <= pending_numbers[0].value;
                in_radix <= pending_numbers[0].radix;
                void'(pending_numbers.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic report_char(input string what, input t_text_char want,
                               input t_text_char got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s: expected char %h last %b bad %b, got char %h last %b bad %b",
                     $realtime, what, want.code, want.last, want.bad,
                     got.code, got.last, got.bad);
    endtask

    // input transfers feed the predictor, output transfers are checked in order
    always @(posedge i_clk) begin
        t_text_char got;
        t_text_char want;
        if (i_rst_n) begin
            if (in_valid && in_ch.ready) begin
                predict_text(in_value, in_radix);
                numbers_taken <= numbers_taken + 1;
            end
            if (out_ch.valid && out_ready) begin
                got = '{out_ch.character, out_ch.last, out_ch.bad_radix};
                chars_checked++;
                if (got.bad)
                    bad_radix_seen++;
                if (got.code == itr_pkg::CHAR_MINUS)
                    minus_seen++;
                if (expected_chars.size() == 0) begin
                    report_char("unexpected transfer", '0, got);
                end else begin
                    want = expected_chars.pop_front();
                    if (got !== want)
                        report_char("mismatch", want, got);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ch.ready) || (out_ch.valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d numbers taken",
                     $realtime, STALL_LIMIT, numbers_taken);
            $display("** integer_to_radix_text: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // zero in a few bases
        add_number(32'd0, itr_pkg::DECIMAL_RADIX);
        add_number(32'd0, itr_pkg::RADIX_MIN);
        add_number(32'd0, itr_pkg::RADIX_MAX);
        // most negative value: full magnitude in decimal, raw pattern elsewhere
        add_number(32'h8000_0000, itr_pkg::DECIMAL_RADIX);
        add_number(32'h8000_0000, itr_pkg::RADIX_MIN);
        add_number(32'h8000_0000, 6'd16);
        add_number(32'h7fff_ffff, itr_pkg::DECIMAL_RADIX);
        add_number(32'h7fff_ffff, itr_pkg::RADIX_MAX);
        // all ones: minus one in decimal, longest text in binary
        add_number(32'hffff_ffff, itr_pkg::DECIMAL_RADIX);
        add_number(32'hffff_ffff, itr_pkg::RADIX_MIN);
        add_number(32'hffff_ffff, itr_pkg::RADIX_MAX);
        // digit boundaries: 'z', '9', 'a'
        add_number(32'd35, itr_pkg::RADIX_MAX);
        add_number(32'd9, itr_pkg::DECIMAL_RADIX);
        add_number(32'd10, 6'd11);
        add_number(32'd255, 6'd16);
        add_number(-32'sd12345, itr_pkg::DECIMAL_RADIX);
        add_number(-32'sd8, 6'd8);
        add_number(32'd1, 6'd3);
        add_number(32'haaaa_aaaa, itr_pkg::RADIX_MIN);
        add_number(32'd123456789, itr_pkg::DECIMAL_RADIX);
        // bases out of range on both sides
        add_number(32'd5, 6'd0);
        add_number(32'd5, 6'd1);
        add_number(32'hffff_ffff, 6'd37);
        add_number(32'h1234_5678, 6'd63);

        for (int n = 0; n < RANDOM_NUMBERS; n++)
            add_number(pick_value(), pick_radix());

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_numbers.size() == 0 && !in_valid);
        @(posedge i_clk);
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        mismatches += expected_chars.size();
        $display("converted %0d numbers into %0d checked characters", numbers_taken,
                 chars_checked);
        $display("%0d bad-base results, %0d minus signs, %0d failures", bad_radix_seen,
                 minus_seen, mismatches);
        if (mismatches == 0)
            $display("** integer_to_radix_text: PASSED **");
        else
            $display("** integer_to_radix_text: FAILED **");
        $finish;
    end

endmodule

FILE: integer_to_radix_text.f
rtl/itr_pkg.sv
rtl/itr_if.sv
rtl/itr_ram.sv
rtl/itr_datapath.sv
rtl/itr_ctrl.sv
rtl/integer_to_radix_text.sv
verif/integer_to_radix_text_tb.sv
